>>> rtl/core/cursor_linked_list_engine_macros.svh
// Assertion macros shared by the cursor linked list engine RTL.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define CLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cle_pkg.sv
// Package for the cursor linked list engine: sizes, codes, store request types.
// Used by cle_store and cursor_linked_list_engine; no dependencies.
package cle_pkg;

  localparam int CELLS      = 16;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = $clog2(CELLS + 1);
  localparam int MODE_W     = 3;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 3;
  localparam int COUNT_W    = 5;
  localparam int OUT_DATA_W = ((VAL_W + COUNT_W + 7) / 8) * 8;
  localparam int PAD_W      = OUT_DATA_W - VAL_W - COUNT_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [VAL_W-1:0]  val_t;

  localparam link_t NIL = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FIRST  = 3'd0,
    MODE_INS_LAST   = 3'd1,
    MODE_INS_SORTED = 3'd2,
    MODE_DEL_FIRST  = 3'd3,
    MODE_DEL_ALL    = 3'd4,
    MODE_TRAVERSE   = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_ELEMENT   = 3'd3,
    STAT_EMPTY     = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAKE,
    ST_LINK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    val_t data;
  } val_wr_t;

  function automatic logic is_cell(link_t l);
    return l < LINK_W'(CELLS);
  endfunction

  // link held by an entry that has not been written since reset
  function automatic link_t reset_link(idx_t i);
    if (i == IDX_W'(CELLS - 1)) begin
      return NIL;
    end else begin
      return link_t'(i) + link_t'(1);
    end
  endfunction

endpackage

>>> rtl/core/cle_store.sv
// Cell store: value memory and link memory, one read port, registered read data.
// Depends on cle_pkg. Link entries carry valid bits so reset needs no sweep.
module cle_store (
  input  logic              clk,
  input  logic              rst,
  input  cle_pkg::rd_req_t  rd,
  input  cle_pkg::val_wr_t  vwr,
  input  cle_pkg::link_wr_t lwr,
  output cle_pkg::val_t     rd_val,
  output cle_pkg::link_t    rd_link
);
  import cle_pkg::*;

  val_t             val_mem  [CELLS];
  link_t            link_mem [CELLS];
  logic [CELLS-1:0] link_valid;

  link_t link_q;
  idx_t  idx_q;
  logic  vld_q;

  always_ff @(posedge clk) begin
    if (vwr.we) begin
      val_mem[vwr.addr] <= vwr.data;
    end
    if (lwr.we) begin
      link_mem[lwr.addr] <= lwr.data;
    end
    if (rd.en) begin
      rd_val <= val_mem[rd.addr];
      link_q <= link_mem[rd.addr];
      idx_q  <= rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
      vld_q      <= 1'b0;
    end else begin
      if (lwr.we) begin
        link_valid[lwr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_q <= link_valid[rd.addr];
      end
    end
  end

  assign rd_link = vld_q ? link_q : reset_link(idx_q);

endmodule

>>> rtl/core/cursor_linked_list_engine.sv
// Cursor linked list engine: one singly linked list of signed values in a cell store.
// Depends on cle_pkg, cle_store and cursor_linked_list_engine_macros.svh.
//
// Requests arrive on the s_ channel: s_tuser is the operation (insert first,
// insert last, insert sorted, delete first match, delete all matches,
// traverse), s_tdata the value. Results leave on the m_ channel: m_tuser is
// the status, m_tdata carries the element and the removed count, m_tlast
// marks the final result of a request. Every request gives one result, but a
// traverse of a non-empty list gives one result per element.
// One request is in work at a time; s_tready is high only while idle.
// Inserts take a free cell and then link it in (ST_TAKE, ST_LINK); insert
// last and insert sorted first walk the list to the insertion point, deletes
// walk the list, and traverse gives its elements in list order as it walks.
// A full store, an unused mode, or a delete or traverse of an empty list goes
// straight to the result. s_tready rises with the final result. The walk reads
// one cell per cycle, except that a traverse waits while the result register is held.
// Reset empties the list and chains every cell on the free chain at once.
// A stalled receiver holds the result register; the engine waits on it and
// resumes when the result is taken.
`include "cursor_linked_list_engine_macros.svh"

module cursor_linked_list_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cle_pkg::MODE_W-1:0]     s_tuser,  // mode
  input  logic [cle_pkg::VAL_W-1:0]      s_tdata,  // value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cle_pkg::STAT_W-1:0]     m_tuser,  // status
  output logic [cle_pkg::OUT_DATA_W-1:0] m_tdata,  // element, removed_count, zero pad
  output logic                           m_tlast
);
  import cle_pkg::*;

  state_e state, state_next;

  logic [MODE_W-1:0] mode_q, mode_next;
  val_t              val_q, val_next;
  link_t             cur, cur_next;
  link_t             prev, prev_next;
  logic [CNT_W-1:0]  n, n_next;
  logic [CNT_W-1:0]  removed, removed_next;
  logic              pend, pend_next;
  link_t             pend_tgt, pend_tgt_next;
  logic              full_q, full_next;
  link_t             free_head, free_head_next;
  link_t             list_head, list_head_next;

  rd_req_t  rd;
  val_wr_t  vwr;
  link_wr_t lwr;
  val_t     rd_val;
  link_t    rd_link;

  logic             emit;
  stat_e            emit_status;
  val_t             emit_elem;
  logic             emit_last;
  logic             slot_free;
  logic [CNT_W-1:0] n_inc;
  logic             more, lt, hit, is_del, is_ins_in;

  cle_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .vwr     (vwr),
    .lwr     (lwr),
    .rd_val  (rd_val),
    .rd_link (rd_link)
  );

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign n_inc     = n + CNT_W'(1);
  assign more      = is_cell(rd_link) && (n_inc < CNT_W'(CELLS));
  assign lt        = $signed(rd_val) < $signed(val_q);
  assign hit       = (rd_val == val_q);
  assign is_del    = (mode_q == MODE_DEL_FIRST) || (mode_q == MODE_DEL_ALL);
  assign is_ins_in = (s_tuser == MODE_INS_FIRST) || (s_tuser == MODE_INS_LAST) ||
                     (s_tuser == MODE_INS_SORTED);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (is_ins_in) begin
            if (!is_cell(free_head)) begin
              state_next = ST_FLUSH;
            end else if (s_tuser == MODE_INS_FIRST || !is_cell(list_head)) begin
              state_next = ST_TAKE;
            end else begin
              state_next = ST_WALK;
            end
          end else if (s_tuser == MODE_DEL_FIRST || s_tuser == MODE_DEL_ALL ||
                       s_tuser == MODE_TRAVERSE) begin
            state_next = is_cell(list_head) ? ST_WALK : ST_FLUSH;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_WALK: begin
        unique case (mode_q)
          MODE_INS_LAST:   state_next = more ? ST_WALK : ST_TAKE;
          MODE_INS_SORTED: state_next = (lt && more) ? ST_WALK : ST_TAKE;
          MODE_DEL_FIRST:  state_next = (!hit && more) ? ST_WALK : ST_FLUSH;
          MODE_DEL_ALL:    state_next = more ? ST_WALK : ST_FLUSH;
          MODE_TRAVERSE: begin
            if (slot_free && !more) begin
              state_next = ST_IDLE;
            end
          end
          default:         state_next = ST_FLUSH;
        endcase
      end
      ST_TAKE:  state_next = ST_LINK;
      ST_LINK:  state_next = ST_FLUSH;
      ST_FLUSH: state_next = slot_free ? ST_IDLE : ST_FLUSH;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd             = '0;
    vwr            = '0;
    lwr            = '0;
    emit           = 1'b0;
    emit_status    = STAT_OK;
    emit_elem      = '0;
    emit_last      = 1'b1;
    mode_next      = mode_q;
    val_next       = val_q;
    cur_next       = cur;
    prev_next      = prev;
    n_next         = n;
    removed_next   = removed;
    pend_next      = pend;
    pend_tgt_next  = pend_tgt;
    full_next      = full_q;
    free_head_next = free_head;
    list_head_next = list_head;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mode_next    = s_tuser;
          val_next     = s_tdata;
          cur_next     = list_head;
          prev_next    = NIL;
          n_next       = '0;
          removed_next = '0;
          pend_next    = 1'b0;
          full_next    = is_ins_in && !is_cell(free_head);
          rd.en        = is_cell(list_head);
          rd.addr      = list_head[IDX_W-1:0];
        end
      end
      ST_WALK: begin
        rd.addr = rd_link[IDX_W-1:0];
        unique case (mode_q)
          MODE_INS_LAST, MODE_INS_SORTED: begin
            if (mode_q == MODE_INS_LAST || lt) begin
              prev_next = cur;
              cur_next  = rd_link;
              n_next    = n_inc;
              rd.en     = more;
            end
          end
          MODE_DEL_FIRST, MODE_DEL_ALL: begin
            if (hit) begin
              // unlink cur, push it on the free chain; prev's link is deferred
              lwr            = '{we: 1'b1, addr: cur[IDX_W-1:0], data: free_head};
              free_head_next = cur;
              removed_next   = removed + CNT_W'(1);
              cur_next       = rd_link;
              n_next         = n_inc;
              if (!is_cell(prev)) begin
                list_head_next = rd_link;
              end else begin
                pend_next     = 1'b1;
                pend_tgt_next = rd_link;
              end
              rd.en = (mode_q == MODE_DEL_ALL) && more;
            end else begin
              if (pend) begin
                lwr       = '{we: 1'b1, addr: prev[IDX_W-1:0], data: pend_tgt};
                pend_next = 1'b0;
              end
              prev_next = cur;
              cur_next  = rd_link;
              n_next    = n_inc;
              rd.en     = more;
            end
          end
          MODE_TRAVERSE: begin
            if (slot_free) begin
              emit        = 1'b1;
              emit_status = STAT_ELEMENT;
              emit_elem   = rd_val;
              emit_last   = !more;
              prev_next   = cur;
              cur_next    = rd_link;
              n_next      = n_inc;
              rd.en       = more;
            end
          end
          default: begin
          end
        endcase
      end
      ST_TAKE: begin
        rd.en   = 1'b1;
        rd.addr = free_head[IDX_W-1:0];
      end
      ST_LINK: begin
        free_head_next = rd_link;
        vwr = '{we: 1'b1, addr: free_head[IDX_W-1:0], data: val_q};
        lwr = '{we: 1'b1, addr: free_head[IDX_W-1:0],
                data: (mode_q == MODE_INS_LAST) ? NIL : cur};
        if (!is_cell(prev)) begin
          list_head_next = free_head;
        end else begin
          pend_next     = 1'b1;
          pend_tgt_next = free_head;
        end
      end
      ST_FLUSH: begin
        if (pend) begin
          lwr       = '{we: 1'b1, addr: prev[IDX_W-1:0], data: pend_tgt};
          pend_next = 1'b0;
        end
        if (slot_free) begin
          emit = 1'b1;
          priority if (full_q) begin
            emit_status = STAT_FULL;
          end else if (is_del) begin
            emit_status = (removed != '0) ? STAT_OK : STAT_NOT_FOUND;
          end else if (mode_q == MODE_TRAVERSE) begin
            emit_status = STAT_EMPTY;
          end else begin
            emit_status = STAT_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n         <= '0;
      removed   <= '0;
      pend      <= 1'b0;
      full_q    <= 1'b0;
      free_head <= '0;
      list_head <= NIL;
    end else begin
      state     <= state_next;
      n         <= n_next;
      removed   <= removed_next;
      pend      <= pend_next;
      full_q    <= full_next;
      free_head <= free_head_next;
      list_head <= list_head_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_q   <= mode_next;
    val_q    <= val_next;
    cur      <= cur_next;
    prev     <= prev_next;
    pend_tgt <= pend_tgt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_status;
      m_tdata <= {{PAD_W{1'b0}}, COUNT_W'(removed), emit_elem};
      m_tlast <= emit_last;
    end
  end

  `CLE_ASSERT_IMP(a_emit_slot, emit, slot_free, "result register overwritten")
  `CLE_ASSERT_IMP(a_rw_apart, rd.en && lwr.we, rd.addr != lwr.addr, "link read and write collide")
  `CLE_ASSERT_IMP(a_idle_clean, state == ST_IDLE, !pend, "deferred link left at idle")
  `CLE_ASSERT_IMP(a_removed_bound, state == ST_WALK || state == ST_FLUSH, removed <= n, "removed count exceeds cells walked")
  `CLE_ASSERT_NXT(a_full_reject, s_tvalid && s_tready && is_ins_in && !is_cell(free_head), state == ST_FLUSH && full_q, "full store not rejected")

endmodule
